// ===== rtl/deque_with_dump_defines.svh =====
// assertion macros shared by the deque rtl
`ifndef DEQUE_WITH_DUMP_DEFINES_SVH
`define DEQUE_WITH_DUMP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define DWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dwd_pkg.sv =====
// types and constants for the deque with dump
package dwd_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DUMP       = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

// ===== rtl/dwd_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module dwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/deque_with_dump.sv =====
// deque with dump: ring store in ram, front pointer and occupancy count
//
// channel  dir  handshake         payload
// s        in   s_tvalid/s_tready s_tuser = action, s_tdata = value
// m        out  m_tvalid/m_tready m_tdata = element, occupancy; m_tuser = status; m_tlast
//
// for push, pop, unused codes and an empty dump the result is registered at the
// request edge, and the next request is taken while it drains.
// a non-empty dump holds off requests until its last element is loaded; elements stream
// one per cycle while m is ready, through the ram read port and then the output register.
// back pressure on m stalls the ram reads; nothing is lost or repeated.
// rst clears pointer, count, state and valids; ram contents need no clearing.
`include "deque_with_dump_defines.svh"

module deque_with_dump #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dwd_pkg::ACTION_W-1:0]   s_tuser,   // [2:0] action
  input  logic [dwd_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // [31:0] element, [38:32] occupancy
  output logic [dwd_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
  output logic                           m_tlast
);

  import dwd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  // dump read side
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] issue_left;
  logic          rd_vld;
  logic          rd_last;
  logic [VALUE_W-1:0] rd_data;

  // output register
  logic [VALUE_W-1:0] out_element;
  logic [OCC_W-1:0]   out_occ;
  status_t            out_status;
  logic               out_last;

  logic s_accept;
  logic out_free;
  logic load_out;
  logic ren;
  logic cmd_result;
  logic dump_start;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  status_t cmd_status;

  action_t action;
  logic empty, full;
  logic [AW-1:0] front_inc, front_dec, ptr_inc, back_slot;
  logic [AW:0]   back_sum;

  assign action   = action_t'(s_tuser);
  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign out_free = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign ptr_inc   = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // front + count stays below twice the depth while not full
  assign back_sum  = (AW+1)'(front) + (AW+1)'(count);
  assign back_slot = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                  : AW'(back_sum);

  // command decode
  always_comb begin
    front_next = front;
    count_next = count;
    cmd_status = STAT_OK;
    wr_en      = 1'b0;
    wr_addr    = back_slot;
    dump_start = 1'b0;
    unique case (action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          cmd_status = STAT_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + 1'b1;
          wr_en      = s_accept;
          wr_addr    = front_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          cmd_status = STAT_FULL;
        end else begin
          count_next = count + 1'b1;
          wr_en      = s_accept;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          cmd_status = STAT_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          cmd_status = STAT_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ACT_DUMP: begin
        if (empty) begin
          cmd_status = STAT_EMPTY;
        end else begin
          dump_start = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_result = s_accept && !dump_start;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept && dump_start) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (load_out && rd_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    ren      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = out_free;
      end
      ST_DUMP: begin
        load_out = rd_vld && out_free;
        ren      = (issue_left != '0) && (!rd_vld || load_out);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (s_accept) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_left <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (s_accept && dump_start) begin
        issue_left <= count;
      end else if (ren) begin
        issue_left <= issue_left - 1'b1;
      end
      if (ren) begin
        rd_vld <= 1'b1;
      end else if (load_out) begin
        rd_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && dump_start) begin
      rd_ptr <= front;
    end else if (ren) begin
      rd_ptr <= ptr_inc;
    end
    if (ren) begin
      rd_last <= (issue_left == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd_result || load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_result) begin
      out_element <= '0;
      out_occ     <= OCC_W'(count_next);
      out_status  <= cmd_status;
      out_last    <= 1'b1;
    end else if (load_out) begin
      out_element <= rd_data;
      out_occ     <= OCC_W'(count);
      out_status  <= STAT_OK;
      out_last    <= rd_last;
    end
  end

  dwd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (s_tdata),
    .re    (ren),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  assign m_tdata = {1'b0, out_occ, out_element};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  `DWD_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "occupancy above depth")
  `DWD_ASSERT_NOW(a_no_req_in_dump, state == ST_DUMP, !s_tready, "request taken during dump")
  `DWD_ASSERT_NOW(a_idle_reads_clear, state == ST_IDLE, !rd_vld && issue_left == '0,
                  "dump reads pending while idle")
  `DWD_ASSERT_NEXT(a_last_ends_dump, load_out && rd_last, state == ST_IDLE,
                   "dump did not end after last element")

endmodule

// ===== test/deque_with_dump_test.sv =====
// self-checking stream testbench for deque_with_dump with a mirror of the deque state
`timescale 1ns / 1ps

module deque_with_dump_test;
  import dwd_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int ACT_SPARE_LO = int'(ACT_DUMP) + 1;
  localparam int ACT_SPARE_HI = (1 << ACTION_W) - 1;
  localparam logic [6:0] SINK_PATTERN_BITS = 7'b1011001;

  typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  typedef struct {
    logic [VALUE_W-1:0] element;
    logic               last;
    status_t            status;
    logic [OCC_W-1:0]   occupancy;
  } deque_output_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [ACTION_W-1:0] s_tuser;
  logic [VALUE_W-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [39:0]         m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                m_tlast;

  // mirror of the deque contents
  logic [VALUE_W-1:0] mirror_store [DEPTH];
  int                 mirror_front;
  int                 mirror_count;
  deque_output_t      deque_outputs_due [$];

  int         burst_left;
  bit         sender_gaps;
  sink_mode_t sink_mode;
  int         hold_cycles;
  int         fail_count;
  int         idle_cycles;
  bit         filling;

  deque_with_dump #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void add_output(input logic [VALUE_W-1:0] element, input logic last,
                                     input status_t status);
    deque_output_t item;
    item.element   = element;
    item.last      = last;
    item.status    = status;
    item.occupancy = mirror_count[OCC_W-1:0];
    deque_outputs_due = {deque_outputs_due, item};
  endfunction

  // updates the mirror for one accepted request and queues the outputs it causes
  function automatic void apply_deque_action(input logic [ACTION_W-1:0] act,
                                             input logic [VALUE_W-1:0] value);
    status_t status;
    status = STAT_OK;
    case (act)
      ACT_PUSH_FRONT: begin
        if (mirror_count >= DEPTH) begin
          status = STAT_FULL;
        end else begin
          mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
          mirror_store[mirror_front] = value;
          mirror_count++;
        end
      end
      ACT_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          status = STAT_FULL;
        end else begin
          mirror_store[(mirror_front + mirror_count) % DEPTH] = value;
          mirror_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (mirror_count == 0) begin
          status = STAT_EMPTY;
        end else begin
          mirror_front = (mirror_front + 1) % DEPTH;
          mirror_count--;
        end
      end
      ACT_POP_BACK: begin
        if (mirror_count == 0) status = STAT_EMPTY;
        else mirror_count--;
      end
      ACT_DUMP: begin
        if (mirror_count == 0) begin
          status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < mirror_count; i++)
            add_output(mirror_store[(mirror_front + i) % DEPTH], i == mirror_count - 1,
                       STAT_OK);
          return;
        end
      end
      default: ;
    endcase
    add_output('0, 1'b1, status);
  endfunction

  // offers one request and returns at the edge where it is taken
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= value;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    apply_deque_action(act, value);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] random_push();
    return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
  endfunction

  function automatic logic [ACTION_W-1:0] random_pop();
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  task automatic test_empty_queue();
    sender_gaps = 1'b1;
    sink_mode   = SINK_RANDOM;
    send_request(ACT_POP_FRONT, random_value());
    send_request(ACT_POP_BACK, random_value());
    send_request(ACT_DUMP, random_value());
    for (int code = ACT_SPARE_LO; code <= ACT_SPARE_HI; code++)
      send_request(code[ACTION_W-1:0], random_value());
  endtask

  task automatic test_extreme_values();
    sender_gaps = 1'b0;
    sink_mode   = SINK_ALWAYS;
    send_request(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_request(ACT_PUSH_FRONT, 32'h8000_0000);
    send_request(ACT_PUSH_BACK, '0);
    send_request(ACT_PUSH_FRONT, '1);
    send_request(ACT_PUSH_BACK, 32'h0000_0001);
    send_request(ACT_DUMP, random_value());
    send_request(ACT_POP_FRONT, random_value());
    send_request(ACT_POP_BACK, random_value());
    send_request(ACTION_W'(ACT_SPARE_HI), random_value());
  endtask

  task automatic test_full_queue();
    sender_gaps = 1'b1;
    sink_mode   = SINK_PATTERN;
    while (mirror_count < DEPTH) send_request(random_push(), random_value());
    send_request(ACT_PUSH_FRONT, random_value());
    send_request(ACT_PUSH_BACK, random_value());
    send_request(ACT_DUMP, random_value());
    while (mirror_count > 0) send_request(random_pop(), random_value());
    send_request(random_pop(), random_value());
  endtask

  // receiver holds off while requests keep coming, so the block must stall its input
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    sink_mode   = SINK_RANDOM;
    hold_cycles = LONG_HOLD;
    repeat (24) send_request(ACT_PUSH_BACK, random_value());
    send_request(ACT_DUMP, random_value());
    repeat (8) send_request(random_pop(), random_value());
  endtask

  task automatic test_random_mix(input int n_items);
    logic [ACTION_W-1:0] act;
    int roll;
    for (int k = 0; k < n_items; k++) begin
      if (mirror_count == 0) filling = 1'b1;
      else if (mirror_count >= DEPTH) filling = 1'b0;
      else if ($urandom_range(0, 39) == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (roll < 4) act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      else if (roll < 12) act = ACT_DUMP;
      else if ((roll < 78) == filling) act = random_push();
      else act = random_pop();
      send_request(act, random_value());
    end
  endtask

  initial begin : receiver
    int phase;
    phase = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: m_tready <= 1'b1;
          SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
          default:     m_tready <= SINK_PATTERN_BITS[phase % 7];
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    deque_output_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (deque_outputs_due.size() == 0) begin
        $error("result with nothing outstanding: element %0d, status %0d",
               $signed(m_tdata[31:0]), m_tuser);
        fail_count++;
      end else begin
        want = deque_outputs_due[0];
        deque_outputs_due.delete(0);
        if (m_tdata[31:0] !== want.element) begin
          $error("element: expected %0d, got %0d", $signed(want.element),
                 $signed(m_tdata[31:0]));
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          fail_count++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[38:32] !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, m_tdata[38:32]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("deque_with_dump regression: fail");
      $finish;
    end
  end

  initial begin
    mirror_front = 0;
    mirror_count = 0;
    burst_left   = 0;
    sender_gaps  = 1'b0;
    sink_mode    = SINK_ALWAYS;
    hold_cycles  = 0;
    fail_count   = 0;
    idle_cycles  = 0;
    filling      = 1'b1;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= '0;
    s_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_extreme_values();
    test_full_queue();
    test_backpressure();
    sender_gaps = 1'b1;
    sink_mode   = SINK_RANDOM;
    test_random_mix(60);
    sender_gaps = 1'b0;
    sink_mode   = SINK_ALWAYS;
    test_random_mix(50);
    sender_gaps = 1'b1;
    sink_mode   = SINK_PATTERN;
    test_random_mix(60);
    s_tvalid <= 1'b0;

    while (deque_outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("deque_with_dump regression: pass");
    else $display("deque_with_dump regression: fail");
    $finish;
  end

endmodule

// ===== deque_with_dump.f =====
+incdir+rtl
rtl/dwd_pkg.sv
rtl/dwd_ram.sv
rtl/deque_with_dump.sv
test/deque_with_dump_test.sv
